@@ src/rgb_to_hsv_converter_defines.svh @@
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define HSV_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define HSV_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hsv_pkg.sv @@
// Shared types and constants of the RGB to HSV converter.
`default_nettype none

package hsv_pkg;

    // Width of the hue field on the result channel.
    localparam int HUE_BITS = 15;

    // Degrees in one hue sector, and the integer bits that value needs.
    localparam int SIXTY_DEGREES   = 60;
    localparam int DEGREE_INT_BITS = 6;

    // Sector offsets in units of sixty degrees.
    localparam int GREEN_SECTORS = 2;
    localparam int BLUE_SECTORS  = 4;
    localparam int TURN_SECTORS  = 6;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } hsv_sector_t;

    // Per-pixel control carried along the divider chain.
    typedef struct packed {
        hsv_sector_t sector;
        logic        neg;    // channel difference is negative
        logic        grey;   // delta is zero: hue is zero
        logic        black;  // max is zero: saturation is zero
    } hsv_ctrl_t;

endpackage

`default_nettype wire

@@ src/hsv_pixel_if.sv @@
// Valid/ready channel carrying one RGB pixel.
`default_nettype none

interface hsv_pixel_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ src/hsv_result_if.sv @@
// Valid/ready channel carrying one HSV result.
`default_nettype none

interface hsv_result_if
    import hsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

@@ src/hsv_front.sv @@
// Entry stage: max, min, sector and divider numerators of one pixel.
`default_nettype none

module hsv_front
    import hsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    parameter int QUOT_BITS    = 12,
    parameter int SIXTY        = 3840
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    valid_in,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic                         valid_out,
    output hsv_ctrl_t                    ctrl_out,
    output logic [CHANNEL_BITS-1:0]      max_out,
    output logic [CHANNEL_BITS-1:0]      delta_out,
    output logic [CHANNEL_BITS-1:0]      sat_rem_out,
    output logic [QUOT_BITS-1:0]         sat_nq_out,
    output logic [CHANNEL_BITS-1:0]      hue_rem_out,
    output logic [QUOT_BITS-1:0]         hue_nq_out
);

    localparam int NumW    = CHANNEL_BITS + QUOT_BITS;
    localparam int ChanMax = (1 << CHANNEL_BITS) - 1;

    logic [CHANNEL_BITS-1:0] mx, mn, delta, dif_a, dif_b, mag;
    hsv_sector_t             sector;
    logic                    neg;
    logic [NumW-1:0]         sat_num, hue_num;

    logic                    valid_reg;
    hsv_ctrl_t               ctrl_reg;
    logic [CHANNEL_BITS-1:0] max_reg, delta_reg, sat_rem_reg, hue_rem_reg;
    logic [QUOT_BITS-1:0]    sat_nq_reg, hue_nq_reg;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        delta = mx - mn;

        // first largest channel wins ties
        priority if (red == mx)
        begin
            sector = SECTOR_RED;
            dif_a  = green;
            dif_b  = blue;
        end
        else if (green == mx)
        begin
            sector = SECTOR_GREEN;
            dif_a  = blue;
            dif_b  = red;
        end
        else
        begin
            sector = SECTOR_BLUE;
            dif_a  = red;
            dif_b  = green;
        end

        neg     = dif_a < dif_b;
        mag     = neg ? (dif_b - dif_a) : (dif_a - dif_b);
        sat_num = NumW'(delta) * NumW'(ChanMax);
        hue_num = NumW'(mag) * NumW'(SIXTY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg    <= '{sector: sector, neg: neg, grey: (delta == '0),
                             black: (mx == '0)};
            max_reg     <= mx;
            delta_reg   <= delta;
            sat_rem_reg <= sat_num[NumW-1:QUOT_BITS];
            sat_nq_reg  <= sat_num[QUOT_BITS-1:0];
            hue_rem_reg <= hue_num[NumW-1:QUOT_BITS];
            hue_nq_reg  <= hue_num[QUOT_BITS-1:0];
        end
    end

    assign valid_out   = valid_reg;
    assign ctrl_out    = ctrl_reg;
    assign max_out     = max_reg;
    assign delta_out   = delta_reg;
    assign sat_rem_out = sat_rem_reg;
    assign sat_nq_out  = sat_nq_reg;
    assign hue_rem_out = hue_rem_reg;
    assign hue_nq_out  = hue_nq_reg;

endmodule

`default_nettype wire

@@ src/hsv_div_cell.sv @@
// One restoring-division cell: resolve one quotient bit of both dividers.
`default_nettype none

module hsv_div_cell
    import hsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    parameter int QUOT_BITS    = 12
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    valid_in,
    input  wire hsv_ctrl_t               ctrl_in,
    input  wire logic [CHANNEL_BITS-1:0] max_in,
    input  wire logic [CHANNEL_BITS-1:0] delta_in,
    input  wire logic [CHANNEL_BITS-1:0] sat_rem_in,
    input  wire logic [QUOT_BITS-1:0]    sat_nq_in,
    input  wire logic [CHANNEL_BITS-1:0] hue_rem_in,
    input  wire logic [QUOT_BITS-1:0]    hue_nq_in,
    output logic                         valid_out,
    output hsv_ctrl_t                    ctrl_out,
    output logic [CHANNEL_BITS-1:0]      max_out,
    output logic [CHANNEL_BITS-1:0]      delta_out,
    output logic [CHANNEL_BITS-1:0]      sat_rem_out,
    output logic [QUOT_BITS-1:0]         sat_nq_out,
    output logic [CHANNEL_BITS-1:0]      hue_rem_out,
    output logic [QUOT_BITS-1:0]         hue_nq_out
);

    // Remainder shifts in the next numerator bit; quotient bits fill from the bottom.
    logic [CHANNEL_BITS:0]   sat_trial, hue_trial, sat_diff, hue_diff;
    logic                    sat_ge, hue_ge;
    logic [CHANNEL_BITS-1:0] sat_rem_next, hue_rem_next;
    logic [QUOT_BITS-1:0]    sat_nq_next, hue_nq_next;

    logic                    valid_reg;
    hsv_ctrl_t               ctrl_reg;
    logic [CHANNEL_BITS-1:0] max_reg, delta_reg, sat_rem_reg, hue_rem_reg;
    logic [QUOT_BITS-1:0]    sat_nq_reg, hue_nq_reg;

    always_comb
    begin
        sat_trial    = {sat_rem_in, sat_nq_in[QUOT_BITS-1]};
        sat_diff     = sat_trial - {1'b0, max_in};
        sat_ge       = sat_trial >= {1'b0, max_in};
        sat_rem_next = sat_ge ? sat_diff[CHANNEL_BITS-1:0] : sat_trial[CHANNEL_BITS-1:0];
        sat_nq_next  = {sat_nq_in[QUOT_BITS-2:0], sat_ge};

        hue_trial    = {hue_rem_in, hue_nq_in[QUOT_BITS-1]};
        hue_diff     = hue_trial - {1'b0, delta_in};
        hue_ge       = hue_trial >= {1'b0, delta_in};
        hue_rem_next = hue_ge ? hue_diff[CHANNEL_BITS-1:0] : hue_trial[CHANNEL_BITS-1:0];
        hue_nq_next  = {hue_nq_in[QUOT_BITS-2:0], hue_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg    <= ctrl_in;
            max_reg     <= max_in;
            delta_reg   <= delta_in;
            sat_rem_reg <= sat_rem_next;
            sat_nq_reg  <= sat_nq_next;
            hue_rem_reg <= hue_rem_next;
            hue_nq_reg  <= hue_nq_next;
        end
    end

    assign valid_out   = valid_reg;
    assign ctrl_out    = ctrl_reg;
    assign max_out     = max_reg;
    assign delta_out   = delta_reg;
    assign sat_rem_out = sat_rem_reg;
    assign sat_nq_out  = sat_nq_reg;
    assign hue_rem_out = hue_rem_reg;
    assign hue_nq_out  = hue_nq_reg;

endmodule

`default_nettype wire

@@ src/hsv_skid.sv @@
// Output register with one skid entry; upstream ready is registered.
`default_nettype none

module hsv_skid #(
    parameter int DATA_BITS = 31
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    input  wire logic [DATA_BITS-1:0] push_data,
    output logic                      push_ready,
    output logic                      out_valid,
    output logic [DATA_BITS-1:0]      out_data,
    input  wire logic                 out_ready
);

    logic                 o_valid_reg, s_valid_reg;
    logic [DATA_BITS-1:0] o_data_reg, s_data_reg;
    logic                 push;

    assign push = push_valid && !s_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (!o_valid_reg || out_ready)
        begin
            // output slot frees: drain the skid entry first
            if (s_valid_reg)
            begin
                o_valid_reg <= 1'b1;
                s_valid_reg <= 1'b0;
            end
            else
            begin
                o_valid_reg <= push;
            end
        end
        else if (push)
        begin
            s_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!o_valid_reg || out_ready)
        begin
            o_data_reg <= s_valid_reg ? s_data_reg : push_data;
        end
        else if (push)
        begin
            s_data_reg <= push_data;
        end
    end

    assign push_ready = !s_valid_reg;
    assign out_valid  = o_valid_reg;
    assign out_data   = o_data_reg;

endmodule

`default_nettype wire

@@ src/rgb_to_hsv_converter.sv @@
// Top level of the pipelined RGB to HSV converter.
//
// Channels: pixel (sink) takes one RGB pixel per beat; result (source) gives
// hue, saturation and brightness (the largest channel) for that pixel, in order.
// Hue counts 2^-HUE_FRACTION_BITS degree units (1/64 degree by default).
// Throughput: one pixel per clock cycle, sustained, as long as result.ready
// stays high. Each cell of the divider chain resolves one quotient bit of both
// divisions (saturation and hue term) and hands on its remainder unless stalled.
// Path: one entry stage, one cell per quotient bit and one output register
// from pixel beat to result beat, where QuotBits = max(CHANNEL_BITS,
// HUE_FRACTION_BITS + 6) is the number of quotient bits.
// Stall: when result.ready drops, a skid entry catches the pixel already in
// flight; pixel.ready then falls on the next cycle and the whole pipeline
// holds. pixel.ready comes from a register, never from result.ready.
// Reset: rst_n clears all valid flags; no pixel is in flight after reset and
// pixel.ready is high from the first cycle on.
`default_nettype none

`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter
    import hsv_pkg::*;
#(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hsv_pixel_if.sink    pixel,
    hsv_result_if.source result
);

    localparam int Sixty     = SIXTY_DEGREES << HUE_FRACTION_BITS;
    localparam int BaseGreen = GREEN_SECTORS * Sixty;
    localparam int BaseBlue  = BLUE_SECTORS * Sixty;
    localparam int FullTurn  = TURN_SECTORS * Sixty;
    localparam int QuotBits  = (CHANNEL_BITS > HUE_FRACTION_BITS + DEGREE_INT_BITS) ?
                               CHANNEL_BITS : HUE_FRACTION_BITS + DEGREE_INT_BITS;
    localparam int HueW      = $clog2(FullTurn + 1);
    localparam int HueW2     = (HueW > HUE_BITS) ? HueW : HUE_BITS;
    localparam int ArithW    = (HueW2 > QuotBits) ? HueW2 : QuotBits;
    localparam int DataW     = HUE_BITS + 2 * CHANNEL_BITS;

    // Stage 0 is the entry stage; stage k holds k resolved quotient bits.
    logic                    valid_s   [QuotBits+1];
    hsv_ctrl_t               ctrl_s    [QuotBits+1];
    logic [CHANNEL_BITS-1:0] max_s     [QuotBits+1];
    logic [CHANNEL_BITS-1:0] delta_s   [QuotBits+1];
    logic [CHANNEL_BITS-1:0] sat_rem_s [QuotBits+1];
    logic [QuotBits-1:0]     sat_nq_s  [QuotBits+1];
    logic [CHANNEL_BITS-1:0] hue_rem_s [QuotBits+1];
    logic [QuotBits-1:0]     hue_nq_s  [QuotBits+1];

    logic                    pipe_ready;
    hsv_ctrl_t               ctrl_last;
    logic [ArithW-1:0]       term, base, hue_wide;
    logic [CHANNEL_BITS-1:0] sat_final;
    logic [DataW-1:0]        push_data, out_data;

    // Whole pipeline advances together; the skid entry absorbs one stall beat.
    assign pixel.ready = pipe_ready;

    hsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .QUOT_BITS    (QuotBits),
        .SIXTY        (Sixty)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_ready),
        .valid_in    (pixel.valid),
        .red         (pixel.red),
        .green       (pixel.green),
        .blue        (pixel.blue),
        .valid_out   (valid_s[0]),
        .ctrl_out    (ctrl_s[0]),
        .max_out     (max_s[0]),
        .delta_out   (delta_s[0]),
        .sat_rem_out (sat_rem_s[0]),
        .sat_nq_out  (sat_nq_s[0]),
        .hue_rem_out (hue_rem_s[0]),
        .hue_nq_out  (hue_nq_s[0])
    );

    for (genvar k = 0; k < QuotBits; k++)
    begin : g_cell
        hsv_div_cell #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .QUOT_BITS    (QuotBits)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (pipe_ready),
            .valid_in    (valid_s[k]),
            .ctrl_in     (ctrl_s[k]),
            .max_in      (max_s[k]),
            .delta_in    (delta_s[k]),
            .sat_rem_in  (sat_rem_s[k]),
            .sat_nq_in   (sat_nq_s[k]),
            .hue_rem_in  (hue_rem_s[k]),
            .hue_nq_in   (hue_nq_s[k]),
            .valid_out   (valid_s[k+1]),
            .ctrl_out    (ctrl_s[k+1]),
            .max_out     (max_s[k+1]),
            .delta_out   (delta_s[k+1]),
            .sat_rem_out (sat_rem_s[k+1]),
            .sat_nq_out  (sat_nq_s[k+1]),
            .hue_rem_out (hue_rem_s[k+1]),
            .hue_nq_out  (hue_nq_s[k+1])
        );
    end

    // Assemble the hue from the sector base and the quotient term.
    assign ctrl_last = ctrl_s[QuotBits];
    assign term      = ArithW'(hue_nq_s[QuotBits]);

    always_comb
    begin
        unique case (ctrl_last.sector)
            SECTOR_RED:   base = '0;
            SECTOR_GREEN: base = ArithW'(BaseGreen);
            SECTOR_BLUE:  base = ArithW'(BaseBlue);
            default:      base = '0;
        endcase

        priority if (ctrl_last.grey)
        begin
            hue_wide = '0;
        end
        else if (!ctrl_last.neg)
        begin
            hue_wide = base + term;
        end
        else if (ctrl_last.sector == SECTOR_RED)
        begin
            // wrap below zero degrees; a zero term stays at zero
            hue_wide = (term == '0) ? '0 : ArithW'(FullTurn) - term;
        end
        else
        begin
            hue_wide = base - term;
        end

        // quotient never exceeds the channel maximum
        sat_final = ctrl_last.black ? '0 : sat_nq_s[QuotBits][CHANNEL_BITS-1:0];
    end

    assign push_data = {hue_wide[HUE_BITS-1:0], sat_final, max_s[QuotBits]};

    hsv_skid #(
        .DATA_BITS (DataW)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (valid_s[QuotBits] && pipe_ready),
        .push_data  (push_data),
        .push_ready (pipe_ready),
        .out_valid  (result.valid),
        .out_data   (out_data),
        .out_ready  (result.ready)
    );

    assign result.hue        = out_data[DataW-1:2*CHANNEL_BITS];
    assign result.saturation = out_data[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign result.brightness = out_data[CHANNEL_BITS-1:0];

    // A full skid entry means a result is waiting at the output.
    `HSV_ASSERT_IMP(a_skid_full_has_output, clk, rst_n, !pipe_ready, result.valid, "skid full without a waiting result")

    // The pipeline only freezes after the output stalled with a result.
    `HSV_ASSERT_IMP(a_freeze_after_stall, clk, rst_n, $fell(pipe_ready), $past(result.valid && !result.ready), "pipeline froze without an output stall")

    // Zero saturation means a grey pixel, whose hue is zero.
    `HSV_ASSERT_IMP(a_grey_hue_zero, clk, rst_n, result.valid && (result.saturation == '0), result.hue == '0, "grey pixel with nonzero hue")

endmodule

`default_nettype wire

@@ test/tb_rgb_to_hsv_converter.sv @@
// Self-checking testbench for the rgb_to_hsv_converter pipeline.
`default_nettype none

module tb_rgb_to_hsv_converter;
    import hsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Default build of the block: 8-bit channels, hue in 1/64 degree.
    localparam int CHANNEL_BITS = 8;
    localparam int PIXEL_BITS   = 3 * CHANNEL_BITS;
    localparam int HUE_FRAC     = 6;
    localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
    localparam int HUE_SIXTY    = 60 << HUE_FRAC;     // 3840
    localparam int HUE_GREEN    = 2 * HUE_SIXTY;      // 7680
    localparam int HUE_BLUE     = 4 * HUE_SIXTY;      // 15360
    localparam int HUE_TURN     = 6 * HUE_SIXTY;      // 23040

    // The drain window leaves room for the pipeline depth and the skid entry.
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_triple_t;

    // One pending conversion: the pixel that went in and what must come out.
    typedef struct {
        rgb_pixel_t  px;
        hsv_triple_t hsv;
    } pending_hsv_t;

    logic clk;
    logic rst_n;

    hsv_pixel_if  #(.CHANNEL_BITS(CHANNEL_BITS)) pixel_bus ();
    hsv_result_if #(.CHANNEL_BITS(CHANNEL_BITS)) result_bus ();

    rgb_to_hsv_converter #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRAC)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus.sink),
        .result (result_bus.source)
    );

    // Conversions accepted on the pixel side and not yet seen on the result side.
    pending_hsv_t pending_hsv_q[$];

    int  mismatch_count  = 0;
    bit  pixel_idle_on   = 1'b1;    // random gaps between pixel beats
    bit  result_idle_on  = 1'b1;    // random stalls between result beats
    int  result_hold_req = 0;       // long hold-off request for the result side

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hue inside one sector: base plus or minus floor(|a-b| * 60deg / delta).
    // A negative offset in the red sector wraps around the full turn.
    function automatic int unsigned hue_in_sector(int unsigned base, int unsigned a,
                                                  int unsigned b, int unsigned delta);
        int unsigned mag;
        int unsigned term;
        mag  = (a >= b) ? a - b : b - a;
        term = (mag * HUE_SIXTY) / delta;
        if (a >= b)
            return base + term;
        if (base == 0)
            return (term == 0) ? 0 : HUE_TURN - term;
        return base - term;
    endfunction

    // Expected hue, saturation and value of one pixel.
    function automatic hsv_triple_t convert_rgb(rgb_pixel_t px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        int unsigned hue;
        int unsigned sat;
        hsv_triple_t res;
        r   = 32'(px.red);
        g   = 32'(px.green);
        b   = 32'(px.blue);
        mx  = r;
        mn  = r;
        hue = 0;
        sat = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        // Black pixel keeps hue and saturation at zero; grey keeps hue at zero.
        if (mx != 0)
        begin
            sat = (delta * CHAN_MAX) / mx;
            if (delta != 0)
            begin
                // Ties go to red first, then green.
                if (r == mx)
                    hue = hue_in_sector(0, g, b, delta);
                else if (g == mx)
                    hue = hue_in_sector(HUE_GREEN, b, r, delta);
                else
                    hue = hue_in_sector(HUE_BLUE, r, g, delta);
            end
        end
        res.hue        = hue[HUE_BITS-1:0];
        res.saturation = sat[CHANNEL_BITS-1:0];
        res.brightness = mx[CHANNEL_BITS-1:0];
        return res;
    endfunction

    // Random pixel, shaped so that ties, greys and tiny deltas show up often.
    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t              px;
        int unsigned             mode;
        logic [CHANNEL_BITS-1:0] v;
        logic [CHANNEL_BITS-1:0] w;
        int                      c;
        mode = $urandom_range(0, 9);
        v    = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
        w    = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
        px   = PIXEL_BITS'($urandom);
        case (mode)
            6:
            begin
                // two channels equal
                case ($urandom_range(0, 2))
                    0: px = '{v, v, w};
                    1: px = '{v, w, v};
                    default: px = '{w, v, v};
                endcase
            end
            7: px = '{v, v, v};
            8:
            begin
                // channels within a few codes of each other
                c = int'(v) + int'($urandom_range(0, 4)) - 2;
                px.red   = CHANNEL_BITS'((c < 0) ? 0 : (c > CHAN_MAX) ? CHAN_MAX : c);
                c = int'(v) + int'($urandom_range(0, 4)) - 2;
                px.green = CHANNEL_BITS'((c < 0) ? 0 : (c > CHAN_MAX) ? CHAN_MAX : c);
                c = int'(v) + int'($urandom_range(0, 4)) - 2;
                px.blue  = CHANNEL_BITS'((c < 0) ? 0 : (c > CHAN_MAX) ? CHAN_MAX : c);
            end
            9:
            begin
                // each channel at an extreme
                px.red   = $urandom_range(0, 1) ? CHANNEL_BITS'(CHAN_MAX) : '0;
                px.green = $urandom_range(0, 1) ? CHANNEL_BITS'(CHAN_MAX) : '0;
                px.blue  = $urandom_range(0, 1) ? CHANNEL_BITS'(CHAN_MAX) : '0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // Offer one pixel: idle for a random gap, then hold valid until the beat.
    // Valid stays high after the beat until the next falling edge decides.
    task automatic send_pixel(rgb_pixel_t px);
        int gap;
        gap = pixel_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            pixel_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pixel_bus.valid <= 1'b1;
        pixel_bus.red   <= px.red;
        pixel_bus.green <= px.green;
        pixel_bus.blue  <= px.blue;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
    endtask

    // Drop valid, then hold the pixel side until every pending conversion
    // has come out.
    task automatic wait_for_results();
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        while (pending_hsv_q.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, each sector, tie breaks and the wrap of the red sector.
    task automatic run_directed();
        rgb_pixel_t cases[$];
        cases = '{
            '{8'd0,   8'd0,   8'd0},     // black
            '{8'd255, 8'd255, 8'd255},   // white
            '{8'd128, 8'd128, 8'd128},   // grey
            '{8'd1,   8'd1,   8'd1},     // darkest grey
            '{8'd255, 8'd0,   8'd0},     // pure red
            '{8'd0,   8'd255, 8'd0},     // pure green
            '{8'd0,   8'd0,   8'd255},   // pure blue
            '{8'd255, 8'd255, 8'd0},     // red/green tie goes to red
            '{8'd0,   8'd255, 8'd255},   // green/blue tie goes to green
            '{8'd255, 8'd0,   8'd255},   // red/blue tie, red sector wraps
            '{8'd255, 8'd0,   8'd10},    // red sector, negative difference
            '{8'd255, 8'd10,  8'd0},     // red sector, positive difference
            '{8'd10,  8'd255, 8'd0},     // green sector, negative difference
            '{8'd0,   8'd255, 8'd10},    // green sector, positive difference
            '{8'd0,   8'd10,  8'd255},   // blue sector, negative difference
            '{8'd10,  8'd0,   8'd255},   // blue sector, positive difference
            '{8'd1,   8'd0,   8'd0},     // smallest nonzero max
            '{8'd255, 8'd254, 8'd254},   // smallest delta at full value
            '{8'd255, 8'd254, 8'd255},   // red/blue tie with small delta
            '{8'd170, 8'd85,  8'd170},   // alternating bit patterns
            '{8'd85,  8'd170, 8'd85},
            '{8'd254, 8'd1,   8'd127}
        };
        foreach (cases[i])
            send_pixel(cases[i]);
    endtask

    // Long random stream; idling is toggled per stretch so back-to-back runs occur.
    task automatic run_random_stream(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                pixel_idle_on  = ($urandom_range(0, 2) != 0);
                result_idle_on = ($urandom_range(0, 2) != 0);
            end
            send_pixel(random_pixel());
        end
        pixel_idle_on  = 1'b1;
        result_idle_on = 1'b1;
    endtask

    // Hold off the result side for a long stretch while pixels keep coming,
    // so the pipeline fills up and drops pixel.ready.
    task automatic run_output_stall();
        pixel_idle_on   = 1'b0;
        result_hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_pixel(random_pixel());
        pixel_idle_on = 1'b1;
    endtask

    // Stop the pixel stream until the pipeline is empty, then resume.
    task automatic run_drain_pause();
        for (int i = 0; i < 10; i++)
            send_pixel(random_pixel());
        wait_for_results();
        for (int i = 0; i < 10; i++)
            send_pixel(random_pixel());
    endtask

    // Result side: stall a random number of cycles per beat, or serve a long
    // hold-off when one is requested. Ready never toggles twice in one step.
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (result_hold_req > 0)
            begin
                stall           = result_hold_req;
                result_hold_req = 0;
            end
            else
            begin
                stall = result_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
        end
    end

    // Monitor: record each pixel beat, then check each result beat against the
    // oldest pending conversion. Both happen in one process, so order is fixed.
    always @(posedge clk)
    begin
        pending_hsv_t entry;
        rgb_pixel_t   px;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            px        = '{pixel_bus.red, pixel_bus.green, pixel_bus.blue};
            entry.px  = px;
            entry.hsv = convert_rgb(px);
            pending_hsv_q.push_back(entry);
        end
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_hsv_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with no pending pixel: hue %0d sat %0d val %0d",
                             $realtime, result_bus.hue, result_bus.saturation,
                             result_bus.brightness);
            end
            else
            begin
                entry = pending_hsv_q.pop_front();
                if (result_bus.hue !== entry.hsv.hue
                    || result_bus.saturation !== entry.hsv.saturation
                    || result_bus.brightness !== entry.hsv.brightness)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: rgb (%0d,%0d,%0d) expected hsv (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                 $realtime, entry.px.red, entry.px.green, entry.px.blue,
                                 entry.hsv.hue, entry.hsv.saturation, entry.hsv.brightness,
                                 result_bus.hue, result_bus.saturation,
                                 result_bus.brightness);
                end
            end
        end
    end

    // Main sequence: reset once, run each test, drain, report.
    initial
    begin
        rst_n           = 1'b0;
        pixel_bus.valid = 1'b0;
        pixel_bus.red   = '0;
        pixel_bus.green = '0;
        pixel_bus.blue  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_output_stall();
        run_drain_pause();
        run_random_stream(RANDOM_ITEMS);

        // Drop valid after the last beat and let the pipeline empty out.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_hsv_q.size() == 0)
            $display("rgb_to_hsv_converter test passed");
        else
            $display("rgb_to_hsv_converter test failed");
        $finish;
    end

    // Watchdog: ends a hung run with a failure report.
    initial
    begin
        #2_000_000;
        $display("rgb_to_hsv_converter test failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/hsv_pkg.sv
src/hsv_pixel_if.sv
src/hsv_result_if.sv
src/hsv_front.sv
src/hsv_div_cell.sv
src/hsv_skid.sv
src/rgb_to_hsv_converter.sv
test/tb_rgb_to_hsv_converter.sv
